### src/swrg_pkg.sv
`timescale 1ns / 1ps

package swrg_pkg;

  localparam int unsigned TIME_W = 32;

  // Threshold value loaded at reset.
  localparam logic [TIME_W-1:0] THRESHOLD_RESET = 32'd7;

  // One check request.
  typedef struct packed {
    logic [TIME_W-1:0] check_time;
    logic [TIME_W-1:0] store_time;
    logic              event_pending;
  } swrg_in_t;

  // One gate decision.
  typedef struct packed {
    logic allowed;
    logic clear_event;
  } swrg_out_t;

endpackage

### src/sliding_window_event_rate_gate.sv
`timescale 1ns / 1ps

// Sliding-window event rate gate.
//
// Input channel (in_valid / in_ready / in_data) carries one check request per
// transaction: check time, store time and the pending-event flag. The result
// channel (out_valid / out_ready / out_data) returns exactly one decision per
// request, in order: allowed, and clear_event when the event must be cleared.
// The window threshold is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle; the block does not enforce it.
//
// A request that is accepted sits in the input register; its result is then
// computed from there and written into the output register, where the
// receiver can take it. A stalled receiver can hold it in the input register.
// Throughput is one request per cycle while the receiver does not stall; the
// window test, index update and stamp write all happen in the same cycle,
// between the input register and the output register.
// Reset (synchronous, rst_n low) empties the history, clears the slot index
// and loads the threshold with 7. When the receiver stalls, the result is
// held in the output register and one more request still enters the input
// register before in_ready drops.
module sliding_window_event_rate_gate import swrg_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swrg_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output swrg_out_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data
);

  logic [TIME_W-1:0] threshold_r;
  swrg_in_t          s1_data_r;
  logic              s1_valid_r;
  logic              s1_go;
  logic              in_fire;
  swrg_out_t         core_result;
  swrg_out_t         out_data_r;
  logic              out_valid_r;
  logic              hist_full;

  // Pipeline handshakes.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
  end

  // Window logic and history state.
  swrg_core #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_go),
    .item      (s1_data_r),
    .threshold (threshold_r),
    .result    (core_result),
    .hist_full (hist_full)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A clear request is only ever issued for an allowed transaction.
  a_clear_implies_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.clear_event || out_data_r.allowed))
    else $error("clear_event issued for a refused transaction");

  // Once the history has filled it stays full until reset.
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    hist_full |=> hist_full)
    else $error("history-full flag dropped without reset");

  // While the history is not full every transaction is allowed.
  a_allow_when_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !hist_full) |=> out_data_r.allowed)
    else $error("transaction refused before history was full");

endmodule

### src/swrg_core.sv
`timescale 1ns / 1ps

module swrg_core import swrg_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  swrg_in_t          item,
  input  logic [TIME_W-1:0] threshold,
  output swrg_out_t         result,
  output logic              hist_full
);

  localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

  // The timestamp history is kept as a shift line: tap 0 holds the newest
  // stamp and the last tap holds the oldest one, which is the slot after the
  // current slot index in ring order.
  logic [TIME_W-1:0] taps_r [HISTORY_DEPTH];
  logic [IDX_W-1:0]  slot_idx_r;
  logic [IDX_W-1:0]  slot_idx_nxt;
  logic              full_r;
  logic              full_nxt;
  logic [TIME_W-1:0] age;
  logic              refuse;
  logic              wrap;

  // Window test against the oldest stamp, with a wrapping difference.
  always_comb begin
    age    = item.check_time - taps_r[HISTORY_DEPTH-1];
    refuse = full_r && (age <= threshold);
    result.allowed     = !refuse;
    result.clear_event = !refuse && item.event_pending;
  end

  // Slot index and history-full flag.
  always_comb begin
    wrap         = (slot_idx_r == LAST_IDX);
    slot_idx_nxt = slot_idx_r;
    full_nxt     = full_r;
    if (fire && !refuse && item.event_pending) begin
      slot_idx_nxt = wrap ? '0 : slot_idx_r + 1'b1;
      if (wrap) begin
        full_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_idx_r <= '0;
      full_r     <= 1'b0;
    end else begin
      slot_idx_r <= slot_idx_nxt;
      full_r     <= full_nxt;
    end
  end

  // Stamp history: an allowed request with a pending event pushes a new stamp
  // and drops the oldest; any other allowed request overwrites the newest stamp.
  // Stamps are only read once the history is full, so they need no reset.
  always_ff @(posedge clk) begin
    if (fire && !refuse) begin
      taps_r[0] <= item.store_time;
      if (item.event_pending) begin
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
          taps_r[i] <= taps_r[i-1];
        end
      end
    end
  end

  assign hist_full = full_r;

endmodule

### test/tb_sliding_window_event_rate_gate.sv
`timescale 1ns / 1ps

module tb_sliding_window_event_rate_gate;
  import swrg_pkg::*;

  localparam int unsigned HISTORY_DEPTH = 5;
  // A result passes the input and output registers after its request is taken; this is slack.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  swrg_in_t          in_data;
  logic              out_valid;
  logic              out_ready;
  swrg_out_t         out_data;
  logic              cfg_wr_en;
  logic [TIME_W-1:0] cfg_wr_data;

  // Predicted gate state, kept in step with every accepted request.
  logic [TIME_W-1:0] gate_threshold;
  logic [TIME_W-1:0] stamp_hist [HISTORY_DEPTH];
  int unsigned       slot_ptr;
  logic              hist_full;

  swrg_out_t   expected_decisions [$];
  int unsigned error_count;
  int unsigned idle_pct;
  int unsigned stall_pct;

  sliding_window_event_rate_gate #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Oldest timestamp, the one the window test looks at.
  function automatic logic [TIME_W-1:0] oldest_stamp();
    return stamp_hist[(slot_ptr + 1) % HISTORY_DEPTH];
  endfunction

  // Decide one request and update the predicted history.
  function automatic swrg_out_t predict_gate(input swrg_in_t req);
    int unsigned       nxt;
    logic [TIME_W-1:0] age;
    swrg_out_t         decision;
    nxt = (slot_ptr + 1) % HISTORY_DEPTH;
    decision = '0;
    if (hist_full) begin
      age = req.check_time - stamp_hist[nxt];
      if (age <= gate_threshold) begin
        return decision;
      end
    end
    decision.allowed = 1'b1;
    if (req.event_pending) begin
      decision.clear_event = 1'b1;
      slot_ptr = nxt;
      if (nxt == 0) begin
        hist_full = 1'b1;
      end
    end
    stamp_hist[slot_ptr] = req.store_time;
    return decision;
  endfunction

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    swrg_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_decisions.size() == 0) begin
        report_mismatch($sformatf("unexpected result %b", out_data));
      end else begin
        want = expected_decisions.pop_front();
        if (out_data.allowed !== want.allowed) begin
          report_mismatch($sformatf("allowed %b, expected %b",
                                    out_data.allowed, want.allowed));
        end
        if (out_data.clear_event !== want.clear_event) begin
          report_mismatch($sformatf("clear_event %b, expected %b",
                                    out_data.clear_event, want.clear_event));
        end
      end
    end
  end

  // Send one request; returns right after the edge that accepts it, with
  // valid still high, so the caller must send again or settle at once.
  task automatic send_request(input logic [TIME_W-1:0] check,
                              input logic [TIME_W-1:0] store,
                              input logic ev);
    swrg_in_t req;
    req.check_time    = check;
    req.store_time    = store;
    req.event_pending = ev;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_decisions.push_back(predict_gate(req));
  endtask

  // Stop sending and wait until every decision has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_decisions.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the window threshold; the block must be idle.
  task automatic set_threshold(input logic [TIME_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gate_threshold = value;
    @(posedge clk);
  endtask

  // Random request, mostly aimed at the window boundary.
  task automatic send_random_request();
    int unsigned       pick;
    logic [TIME_W-1:0] check;
    logic [TIME_W-1:0] store;
    pick = $urandom_range(9);
    if (pick < 6) begin
      check = oldest_stamp() + gate_threshold - 32'd3 + $urandom_range(6);
    end else if (pick < 8) begin
      check = $urandom();
    end else if (pick == 8) begin
      // Check time before the oldest stamp wraps to a large age.
      check = oldest_stamp() - $urandom_range(1, 16);
    end else begin
      check = $urandom_range(1) ? TIME_MAX : '0;
    end
    if ($urandom_range(3) == 0) begin
      store = $urandom();
    end else begin
      store = check + $urandom_range(1, 40);
    end
    send_request(check, store, $urandom_range(3) != 0);
  endtask

  // Fill the history under the reset threshold and probe the window edge.
  task automatic test_fill_and_window();
    idle_pct  = 0;
    stall_pct = 0;
    // Without a pending event the current slot is just overwritten.
    send_request('0, '0, 1'b0);
    send_request(TIME_MAX, TIME_MAX, 1'b0);
    // Five events wrap the index and mark the history full.
    send_request(32'd10, 32'd100, 1'b1);
    send_request(32'd20, 32'd110, 1'b1);
    send_request(32'd30, 32'd120, 1'b1);
    send_request(32'd40, 32'd130, 1'b1);
    send_request(32'd50, 32'd140, 1'b1);
    // Oldest stamp is 100: age 7 is refused, age 8 passes.
    send_request(32'd107, 32'd150, 1'b1);
    send_request(32'd108, 32'd150, 1'b1);
    // A check time before the oldest stamp gives a wrapped, large age.
    send_request(32'd50, 32'hFFFF_FFF0, 1'b0);
    send_request(32'd117, 32'd160, 1'b1);
    send_request(32'd118, '0, 1'b1);
    send_request(TIME_MAX, 32'h5555_5555, 1'b1);
    send_request('0, 32'hAAAA_AAAA, 1'b0);
    settle();
  endtask

  // Threshold at zero and at its maximum.
  task automatic test_threshold_extremes();
    idle_pct  = 0;
    stall_pct = 50;
    set_threshold('0);
    // Age zero is still inside the window.
    send_request(oldest_stamp(), 32'h0000_1000, 1'b1);
    send_request(oldest_stamp(), 32'h0000_1001, 1'b0);
    send_request(oldest_stamp() + 32'd1, 32'h0000_1002, 1'b1);
    send_request(oldest_stamp() + 32'd1, 32'h0000_1003, 1'b1);
    settle();
    // Every request is refused once the history is full.
    set_threshold(TIME_MAX);
    send_request(oldest_stamp() - 32'd1, 32'h0000_2000, 1'b1);
    send_request($urandom(), $urandom(), 1'b1);
    send_request(TIME_MAX, '0, 1'b0);
    send_request('0, TIME_MAX, 1'b1);
    settle();
  endtask

  // Random traffic over all idling phases and a range of thresholds.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned half;
    int unsigned n;
    logic [TIME_W-1:0] thresholds [8];
    thresholds[0] = $urandom_range(2, 40);
    thresholds[1] = $urandom();
    thresholds[2] = 32'd1;
    thresholds[3] = 32'd20;
    thresholds[4] = '0;
    thresholds[5] = 32'd12;
    thresholds[6] = 32'h8000_0000;
    thresholds[7] = THRESHOLD_RESET;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (half = 0; half < 2; half++) begin
        set_threshold(thresholds[phase * 2 + half]);
        for (n = 0; n < 56; n++) begin
          send_random_request();
        end
        settle();
      end
    end
  endtask

  initial begin
    int i;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    error_count = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    gate_threshold = THRESHOLD_RESET;
    for (i = 0; i < HISTORY_DEPTH; i++) begin
      stamp_hist[i] = '0;
    end
    slot_ptr  = 0;
    hist_full = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_window();
    test_threshold_extremes();
    test_random_traffic();

    if (error_count == 0) begin
      $display("tb_sliding_window_event_rate_gate passed");
    end else begin
      $display("tb_sliding_window_event_rate_gate failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("tb_sliding_window_event_rate_gate failed");
    $finish;
  end

endmodule
